/* rtl/pd_line_follow_motor_drive_top_macros.svh */
// Assertion macros for the PD line-follow motor drive.
// Define ASSERT_OFF to compile the checks out.
`ifndef PD_LINE_FOLLOW_MOTOR_DRIVE_TOP_MACROS_SVH
`define PD_LINE_FOLLOW_MOTOR_DRIVE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check on every clock edge, suspended while reset is high.
`define PDLF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define PDLF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PDLF_ASSERT(label, clk, rst, prop, msg)
`define PDLF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/pdlf_pkg.sv */
package pdlf_pkg;

   // Field sizes
   localparam int SAMPLE_BITS = 12;
   localparam int DUTY_BITS   = 16;
   localparam int PROP_W      = 10;
   localparam int DERIV_W     = 12;
   localparam int THRESH_W    = 12;
   localparam int STEER_W     = 27;

   // Derived arithmetic widths
   localparam int ERR_W   = SAMPLE_BITS + 1;
   localparam int DIFF_W  = SAMPLE_BITS + 2;
   localparam int PPROD_W = PROP_W + 1 + ERR_W;
   localparam int DPROD_W = DERIV_W + 1 + DIFF_W;
   localparam int CORR_W  = ((PPROD_W > DPROD_W) ? PPROD_W : DPROD_W) + 1;
   localparam int SUM_W   = ((DUTY_BITS + 1 > CORR_W) ? DUTY_BITS + 1 : CORR_W) + 1;
   localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = (DUTY_BITS > DERIV_W) ? DUTY_BITS : DERIV_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_DERIV_GAIN     = 3'd1,
      CSR_BASE_SPEED     = 3'd2,
      CSR_MAX_SPEED      = 3'd3,
      CSR_BACK_SPEED     = 3'd4,
      CSR_LINE_THRESHOLD = 3'd5
   } csr_index_type;

   // Reset values
   localparam logic [PROP_W-1:0]    PROP_GAIN_RST  = PROP_W'(70);
   localparam logic [DERIV_W-1:0]   DERIV_GAIN_RST = DERIV_W'(600);
   localparam logic [DUTY_BITS-1:0] BASE_SPEED_RST = DUTY_BITS'(30000);
   localparam logic [DUTY_BITS-1:0] MAX_SPEED_RST  = DUTY_BITS'(50000);
   localparam logic [DUTY_BITS-1:0] BACK_SPEED_RST = DUTY_BITS'(10000);
   localparam logic [THRESH_W-1:0]  THRESHOLD_RST  = THRESH_W'(500);

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [DUTY_BITS-1:0]     duty_type;
   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [CORR_W-1:0] corr_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [STEER_W-1:0] steer_type;

   localparam corr_type STEER_HI = corr_type'((64'sd1 <<< (STEER_W - 1)) - 64'sd1);
   localparam corr_type STEER_LO = corr_type'(-(64'sd1 <<< (STEER_W - 1)));

   // Saturate the correction to the steer report range
   function automatic steer_type sat_steer(input corr_type corr);
      steer_type res;
      if (corr > STEER_HI) begin
         res = STEER_HI[STEER_W-1:0];
      end else if (corr < STEER_LO) begin
         res = STEER_LO[STEER_W-1:0];
      end else begin
         res = corr[STEER_W-1:0];
      end
      return res;
   endfunction

   // Clamp a wheel sum to 0..limit
   function automatic duty_type clamp_duty(input sum_type value, input duty_type limit);
      duty_type res;
      sum_type  lim_ext;
      lim_ext = sum_type'({1'b0, limit});
      if (value < 0) begin
         res = '0;
      end else if (value > lim_ext) begin
         res = limit;
      end else begin
         res = value[DUTY_BITS-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/pdlf_channels.sv */
// Sensor sample pair channel
interface pdlf_req_if;
   logic                 valid;
   logic                 ready;
   pdlf_pkg::sample_type right_sample;
   pdlf_pkg::sample_type left_sample;

   modport source (output valid, output right_sample, output left_sample, input ready);
   modport sink   (input valid, input right_sample, input left_sample, output ready);
endinterface

// Drive result channel
interface pdlf_rsp_if;
   logic                 valid;
   logic                 ready;
   pdlf_pkg::duty_type   left_fwd_duty;
   pdlf_pkg::duty_type   right_fwd_duty;
   pdlf_pkg::duty_type   left_rev_duty;
   pdlf_pkg::duty_type   right_rev_duty;
   pdlf_pkg::steer_type  steer_term;
   logic                 line_lost;

   modport source (output valid, output left_fwd_duty, output right_fwd_duty,
                   output left_rev_duty, output right_rev_duty, output steer_term,
                   output line_lost, input ready);
   modport sink   (input valid, input left_fwd_duty, input right_fwd_duty,
                   input left_rev_duty, input right_rev_duty, input steer_term,
                   input line_lost, output ready);
endinterface

/* rtl/pd_line_follow_motor_drive_top.sv */
// PD line-follow motor drive.
// req_port carries one word per control tick: a right and a left line
// sensor sample. rsp_port returns one word per request: left/right forward
// and reverse duties, the signed steering correction and a line-lost flag.
// csr_* is a write-only register port (index per csr_index_type); write it
// only while no word is in flight.
// Three register stages (error, gain multiply, sum/clamp output); an
// accepted word passes through all three before rsp_port.valid shows it.
// Throughput: one word per cycle while not stalled; the two gain
// multiplies sit in their own stage, which sets the clock period.
// Each stage holds one word and moves on whenever the stage after it is
// empty or moving, so a stalled receiver backs words up stage by stage;
// req_port.ready drops only while all three stages are full and stalled.
// Reset (synchronous, active high) empties the pipeline, clears the stored
// previous error and loads the default gains, speeds and threshold.
`include "pd_line_follow_motor_drive_top_macros.svh"

module pd_line_follow_motor_drive_top (
   input  logic                                clock,
   input  logic                                reset,
   pdlf_req_if.sink                            req_port,
   pdlf_rsp_if.source                          rsp_port,
   input  logic                                csr_we,
   input  logic [pdlf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdlf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [pdlf_pkg::PROP_W-1:0]   prop_gain_ff;
   logic [pdlf_pkg::DERIV_W-1:0]  deriv_gain_ff;
   pdlf_pkg::duty_type            base_speed_ff;
   pdlf_pkg::duty_type            max_speed_ff;
   pdlf_pkg::duty_type            back_speed_ff;
   logic [pdlf_pkg::THRESH_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= pdlf_pkg::PROP_GAIN_RST;
         deriv_gain_ff <= pdlf_pkg::DERIV_GAIN_RST;
         base_speed_ff <= pdlf_pkg::BASE_SPEED_RST;
         max_speed_ff  <= pdlf_pkg::MAX_SPEED_RST;
         back_speed_ff <= pdlf_pkg::BACK_SPEED_RST;
         threshold_ff  <= pdlf_pkg::THRESHOLD_RST;
      end else if (csr_we) begin
         case (pdlf_pkg::csr_index_type'(csr_index))
            pdlf_pkg::CSR_PROP_GAIN:      prop_gain_ff  <= csr_wdata[pdlf_pkg::PROP_W-1:0];
            pdlf_pkg::CSR_DERIV_GAIN:     deriv_gain_ff <= csr_wdata[pdlf_pkg::DERIV_W-1:0];
            pdlf_pkg::CSR_BASE_SPEED:     base_speed_ff <= csr_wdata[pdlf_pkg::DUTY_BITS-1:0];
            pdlf_pkg::CSR_MAX_SPEED:      max_speed_ff  <= csr_wdata[pdlf_pkg::DUTY_BITS-1:0];
            pdlf_pkg::CSR_BACK_SPEED:     back_speed_ff <= csr_wdata[pdlf_pkg::DUTY_BITS-1:0];
            pdlf_pkg::CSR_LINE_THRESHOLD: threshold_ff  <= csr_wdata[pdlf_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage handshakes: a stage takes a word when empty or draining
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic req_acc;

   assign rdy3 = !v3_ff || rsp_port.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_port.ready = rdy1;
   assign req_acc = req_port.valid && rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_port.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: error, error delta, line-lost test; previous error update
   pdlf_pkg::err_type  last_error_ff;
   pdlf_pkg::err_type  err_in;
   pdlf_pkg::diff_type diff_in;
   logic               lost_in;
   logic [pdlf_pkg::CMP_W-1:0] right_cmp, left_cmp, thr_cmp;

   assign err_in  = pdlf_pkg::err_type'({1'b0, req_port.right_sample})
                  - pdlf_pkg::err_type'({1'b0, req_port.left_sample});
   assign diff_in = pdlf_pkg::diff_type'(err_in) - pdlf_pkg::diff_type'(last_error_ff);

   assign right_cmp = pdlf_pkg::CMP_W'(req_port.right_sample);
   assign left_cmp  = pdlf_pkg::CMP_W'(req_port.left_sample);
   assign thr_cmp   = pdlf_pkg::CMP_W'(threshold_ff);
   assign lost_in   = (left_cmp < thr_cmp) && (right_cmp < thr_cmp);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else if (req_acc) begin
         last_error_ff <= err_in;
      end
   end

   pdlf_pkg::err_type  err1_ff;
   pdlf_pkg::diff_type diff1_ff;
   logic               lost1_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         err1_ff  <= err_in;
         diff1_ff <= diff_in;
         lost1_ff <= lost_in;
      end
   end

   // Stage 2: gain multiplies
   logic signed [pdlf_pkg::PPROD_W-1:0] pprod_in, pprod_ff;
   logic signed [pdlf_pkg::DPROD_W-1:0] dprod_in, dprod_ff;
   logic                                lost2_ff;

   assign pprod_in = pdlf_pkg::PPROD_W'($signed({1'b0, prop_gain_ff}))
                   * pdlf_pkg::PPROD_W'(err1_ff);
   assign dprod_in = pdlf_pkg::DPROD_W'($signed({1'b0, deriv_gain_ff}))
                   * pdlf_pkg::DPROD_W'(diff1_ff);

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         pprod_ff <= pprod_in;
         dprod_ff <= dprod_in;
         lost2_ff <= lost1_ff;
      end
   end

   // Stage 3: correction sum, wheel clamp, output register
   pdlf_pkg::corr_type corr_in;
   pdlf_pkg::sum_type  base_ext, left_sum, right_sum;
   pdlf_pkg::duty_type lf_in, rf_in, lr_in, rr_in;

   assign corr_in   = pdlf_pkg::corr_type'(pprod_ff) + pdlf_pkg::corr_type'(dprod_ff);
   assign base_ext  = pdlf_pkg::sum_type'({1'b0, base_speed_ff});
   assign left_sum  = base_ext + pdlf_pkg::sum_type'(corr_in);
   assign right_sum = base_ext - pdlf_pkg::sum_type'(corr_in);

   always_comb begin
      if (lost2_ff) begin
         lf_in = '0;
         rf_in = '0;
         lr_in = back_speed_ff;
         rr_in = back_speed_ff;
      end else begin
         lf_in = pdlf_pkg::clamp_duty(left_sum, max_speed_ff);
         rf_in = pdlf_pkg::clamp_duty(right_sum, max_speed_ff);
         lr_in = '0;
         rr_in = '0;
      end
   end

   pdlf_pkg::duty_type  lf_ff, rf_ff, lr_ff, rr_ff;
   pdlf_pkg::steer_type steer_ff;
   logic                lost3_ff;

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         lf_ff    <= lf_in;
         rf_ff    <= rf_in;
         lr_ff    <= lr_in;
         rr_ff    <= rr_in;
         steer_ff <= pdlf_pkg::sat_steer(corr_in);
         lost3_ff <= lost2_ff;
      end
   end

   assign rsp_port.valid          = v3_ff;
   assign rsp_port.left_fwd_duty  = lf_ff;
   assign rsp_port.right_fwd_duty = rf_ff;
   assign rsp_port.left_rev_duty  = lr_ff;
   assign rsp_port.right_rev_duty = rr_ff;
   assign rsp_port.steer_term     = steer_ff;
   assign rsp_port.line_lost      = lost3_ff;

   // Checks
   `PDLF_ASSERT(a_lost_no_fwd, clock, reset, (v3_ff && lost3_ff) |-> (lf_ff == '0 && rf_ff == '0 && lr_ff == back_speed_ff && rr_ff == back_speed_ff), "line lost but forward drive active")
   `PDLF_ASSERT(a_track_in_range, clock, reset, (v3_ff && !lost3_ff) |-> (lr_ff == '0 && rr_ff == '0 && lf_ff <= max_speed_ff && rf_ff <= max_speed_ff), "tracking duty out of range")
   `PDLF_ASSERT(a_last_error_upd, clock, reset, req_acc |=> (last_error_ff == $past(err_in) && v1_ff), "previous error not taken from accepted word")
   `PDLF_ASSERT(a_stall_holds, clock, reset, (v3_ff && !rsp_port.ready) |=> (v3_ff && $stable(lf_ff) && $stable(steer_ff)), "stalled result changed")
   `PDLF_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (!v1_ff && !v2_ff && !v3_ff), "pipeline not empty after reset")

endmodule
